>>> rtl/flow_byte_packet_counter_assert.svh
// ----------------------------------------------------------------------------
// Flow byte/packet counter assertion macros
// Shorthand for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef FLOW_BYTE_PACKET_COUNTER_ASSERT_SVH
`define FLOW_BYTE_PACKET_COUNTER_ASSERT_SVH

// check an expression at every clock edge out of reset
`define FBPC_ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// check that a condition implies another in the same cycle
`define FBPC_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

>>> rtl/fbpc_pkg.sv
// ----------------------------------------------------------------------------
// Flow byte/packet counter package
// Shared types, codes and constants of the flow counter.
// ----------------------------------------------------------------------------
package fbpc_pkg;

	localparam int KEY_W   = 49;
	localparam int STAMP_W = 48;
	localparam int CNT_W   = 64;

	localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
	localparam logic [7:0]  LOOPBACK_OCTET = 8'd127;

	typedef enum logic [2:0] {
		ST_HIT      = 3'd0,
		ST_INSERT   = 3'd1,
		ST_EVICT    = 3'd2,
		ST_TRUNC    = 3'd3,
		ST_NOT_IPV4 = 3'd4,
		ST_LOOPBACK = 3'd5,
		ST_Q_FOUND  = 3'd6,
		ST_Q_MISS   = 3'd7
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_UPDATE
	} state_t;

	typedef struct packed {
		logic        mode;
		logic        headers_complete;
		logic [15:0] ether_type;
		logic [31:0] source_addr;
		logic [31:0] dest_addr;
		logic [15:0] iface_index;
		logic        flow_dir;
		logic [15:0] frame_length;
		logic [31:0] query_addr;
	} in_t;

	typedef struct packed {
		status_t          status;
		logic [CNT_W-1:0] byte_count;
		logic [CNT_W-1:0] packet_count;
	} out_t;

	typedef struct packed {
		logic [KEY_W-1:0]   key;
		logic [STAMP_W-1:0] stamp;
		logic [CNT_W-1:0]   bytes;
		logic [CNT_W-1:0]   packets;
	} entry_t;

	typedef struct packed {
		logic hit;
		logic older;
	} cmp_t;

	function automatic logic [KEY_W-1:0] make_key(logic [31:0] addr, logic [15:0] iface,
		logic dir);
		return {addr, iface, dir};
	endfunction

endpackage

>>> rtl/fbpc_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module fbpc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> rtl/fbpc_match.sv
// ----------------------------------------------------------------------------
// Flow counter entry compare unit
// Matches one stored entry against the search key and ranks its recency
// against the oldest entry seen so far in the scan.
// ----------------------------------------------------------------------------
module fbpc_match (
	input  logic [fbpc_pkg::KEY_W-1:0]   key,
	input  fbpc_pkg::entry_t             row,
	input  logic [fbpc_pkg::STAMP_W-1:0] best_stamp,
	input  logic                         first,
	output fbpc_pkg::cmp_t               cmp
);

	always_comb begin
		cmp.hit   = (row.key == key);
		cmp.older = first || (row.stamp < best_stamp);
	end

endmodule

>>> rtl/flow_byte_packet_counter.sv
// ----------------------------------------------------------------------------
// Flow byte/packet counter
// Per-flow byte and packet counters in an LRU table keyed by remote IPv4
// address, interface index and direction, with a query mode.
//
//   port group          | dir | handshake   | payload
//   --------------------+-----+-------------+----------------
//   start/busy/item     | in  | start & !busy | fbpc_pkg::in_t
//   done/result         | out | done strobe | fbpc_pkg::out_t
//
// A dropped packet, or a query on an empty table, answers in the cycle after
// the transfer. A count on an empty table goes straight to the update state.
// Otherwise the block scans the filled entries one per cycle through the RAM
// read port and the compare unit up to a hit or the last entry; a count then
// answers from the update state, a query straight from the scan.
// Reset empties the table at once through the fill count; no clearing pass.
// Results are never stalled; each is shown for one cycle only.
// ----------------------------------------------------------------------------
module flow_byte_packet_counter #(
	parameter int TABLE_ENTRIES = 256
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  fbpc_pkg::in_t   item,
	output logic            done,
	output fbpc_pkg::out_t  result
);

	localparam int IDX_W  = $clog2(TABLE_ENTRIES);
	localparam int FILL_W = $clog2(TABLE_ENTRIES + 1);
	localparam int ROW_W  = $bits(fbpc_pkg::entry_t);

	fbpc_pkg::state_t state_q, state_d;

	logic [FILL_W-1:0]            fill_q;
	logic [FILL_W-1:0]            fill_m1;
	logic [fbpc_pkg::STAMP_W-1:0] stamp_q;
	logic                         done_q, done_d;
	logic                         issuing_q;
	logic                         chk_vld_s1;
	logic [IDX_W-1:0]             chk_idx_s1;
	logic [IDX_W-1:0]             issue_q;
	logic [IDX_W-1:0]             hit_idx_q;
	logic [IDX_W-1:0]             lru_idx_q;
	logic [IDX_W-1:0]             last_idx;
	logic [IDX_W-1:0]             wr_idx;
	logic [fbpc_pkg::STAMP_W-1:0] lru_stamp_q;
	logic [fbpc_pkg::KEY_W-1:0]   key_q;
	logic                         mode_q;
	logic                         hit_q;
	logic [15:0]                  len_q;
	fbpc_pkg::entry_t             row_q;
	fbpc_pkg::entry_t             rd_row;
	fbpc_pkg::entry_t             wr_row;
	fbpc_pkg::out_t               result_q;
	fbpc_pkg::cmp_t               cmp;
	fbpc_pkg::status_t            drop_status;
	fbpc_pkg::status_t            upd_status;
	logic [ROW_W-1:0]             rd_data;
	logic                         ram_re, ram_we;
	logic                         full;
	logic                         dropped;
	logic                         scan_end;
	logic [31:0]                  remote;

	assign fill_m1  = fill_q - FILL_W'(1);
	assign last_idx = fill_m1[IDX_W-1:0];
	assign full     = (fill_q == FILL_W'(TABLE_ENTRIES));
	assign rd_row   = fbpc_pkg::entry_t'(rd_data);
	assign scan_end = chk_vld_s1 && (cmp.hit || (chk_idx_s1 == last_idx));

	assign busy   = (state_q != fbpc_pkg::S_IDLE);
	assign done   = done_q;
	assign result = result_q;

	always_comb begin
		remote      = item.flow_dir ? item.dest_addr : item.source_addr;
		dropped     = 1'b1;
		drop_status = fbpc_pkg::ST_TRUNC;
		if (!item.headers_complete) begin
			drop_status = fbpc_pkg::ST_TRUNC;
		end else if (item.ether_type != fbpc_pkg::ETHERTYPE_IPV4) begin
			drop_status = fbpc_pkg::ST_NOT_IPV4;
		end else if (remote[31:24] == fbpc_pkg::LOOPBACK_OCTET) begin
			drop_status = fbpc_pkg::ST_LOOPBACK;
		end else begin
			dropped = 1'b0;
		end
	end

	always_comb begin
		wr_row.key   = key_q;
		wr_row.stamp = stamp_q;
		if (hit_q) begin
			wr_row.bytes   = row_q.bytes + fbpc_pkg::CNT_W'(len_q);
			wr_row.packets = row_q.packets + fbpc_pkg::CNT_W'(1);
			wr_idx         = hit_idx_q;
			upd_status     = fbpc_pkg::ST_HIT;
		end else begin
			wr_row.bytes   = fbpc_pkg::CNT_W'(len_q);
			wr_row.packets = fbpc_pkg::CNT_W'(1);
			if (full) begin
				wr_idx     = lru_idx_q;
				upd_status = fbpc_pkg::ST_EVICT;
			end else begin
				wr_idx     = fill_q[IDX_W-1:0];
				upd_status = fbpc_pkg::ST_INSERT;
			end
		end
	end

	fbpc_match u_match (
		.key        (key_q),
		.row        (rd_row),
		.best_stamp (lru_stamp_q),
		.first      (chk_idx_s1 == '0),
		.cmp        (cmp)
	);

	fbpc_ram #(
		.WIDTH (ROW_W),
		.DEPTH (TABLE_ENTRIES)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (wr_idx),
		.wdata (wr_row),
		.re    (ram_re),
		.raddr (issue_q),
		.rdata (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fbpc_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		ram_re  = 1'b0;
		ram_we  = 1'b0;
		done_d  = 1'b0;
		case (state_q)
			fbpc_pkg::S_IDLE: begin
				if (start) begin
					if (item.mode) begin
						if (fill_q == '0) begin
							done_d = 1'b1;
						end else begin
							state_d = fbpc_pkg::S_SCAN;
						end
					end else if (dropped) begin
						done_d = 1'b1;
					end else if (fill_q == '0) begin
						state_d = fbpc_pkg::S_UPDATE;
					end else begin
						state_d = fbpc_pkg::S_SCAN;
					end
				end
			end
			fbpc_pkg::S_SCAN: begin
				ram_re = issuing_q;
				if (scan_end) begin
					if (mode_q) begin
						done_d  = 1'b1;
						state_d = fbpc_pkg::S_IDLE;
					end else begin
						state_d = fbpc_pkg::S_UPDATE;
					end
				end
			end
			fbpc_pkg::S_UPDATE: begin
				ram_we  = 1'b1;
				done_d  = 1'b1;
				state_d = fbpc_pkg::S_IDLE;
			end
			default: begin
				state_d = fbpc_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q     <= '0;
			stamp_q    <= '0;
			done_q     <= 1'b0;
			issuing_q  <= 1'b0;
			chk_vld_s1 <= 1'b0;
		end else begin
			done_q     <= done_d;
			chk_vld_s1 <= (state_q == fbpc_pkg::S_SCAN) && issuing_q;
			if (state_q == fbpc_pkg::S_IDLE) begin
				issuing_q <= 1'b1;
			end else if (state_q == fbpc_pkg::S_SCAN && issuing_q && issue_q == last_idx) begin
				issuing_q <= 1'b0;
			end
			if (state_q == fbpc_pkg::S_UPDATE) begin
				stamp_q <= stamp_q + fbpc_pkg::STAMP_W'(1);
				if (!hit_q && !full) begin
					fill_q <= fill_q + FILL_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			fbpc_pkg::S_IDLE: begin
				if (start) begin
					mode_q  <= item.mode;
					len_q   <= item.frame_length;
					hit_q   <= 1'b0;
					issue_q <= '0;
					key_q   <= item.mode
						? fbpc_pkg::make_key(item.query_addr, item.iface_index, item.flow_dir)
						: fbpc_pkg::make_key(remote, item.iface_index, item.flow_dir);
					result_q.byte_count   <= '0;
					result_q.packet_count <= '0;
					result_q.status       <= item.mode ? fbpc_pkg::ST_Q_MISS : drop_status;
				end
			end
			fbpc_pkg::S_SCAN: begin
				chk_idx_s1 <= issue_q;
				if (issuing_q && issue_q != last_idx) begin
					issue_q <= issue_q + IDX_W'(1);
				end
				if (chk_vld_s1) begin
					if (cmp.hit) begin
						hit_q     <= 1'b1;
						row_q     <= rd_row;
						hit_idx_q <= chk_idx_s1;
						result_q.status       <= fbpc_pkg::ST_Q_FOUND;
						result_q.byte_count   <= rd_row.bytes;
						result_q.packet_count <= rd_row.packets;
					end else begin
						if (cmp.older) begin
							lru_idx_q   <= chk_idx_s1;
							lru_stamp_q <= rd_row.stamp;
						end
						result_q.status       <= fbpc_pkg::ST_Q_MISS;
						result_q.byte_count   <= '0;
						result_q.packet_count <= '0;
					end
				end
			end
			fbpc_pkg::S_UPDATE: begin
				result_q.status       <= upd_status;
				result_q.byte_count   <= wr_row.bytes;
				result_q.packet_count <= wr_row.packets;
			end
			default: begin
				issue_q <= issue_q;
			end
		endcase
	end

`include "flow_byte_packet_counter_assert.svh"

	`FBPC_ASSERT_ALWAYS(a_fill_bound, clk, arst_n, fill_q <= FILL_W'(TABLE_ENTRIES), "fill count past table size")
	`FBPC_ASSERT_IMPLY(a_evict_full, clk, arst_n, done && result.status == fbpc_pkg::ST_EVICT, full, "eviction with free slots")
	`FBPC_ASSERT_IMPLY(a_insert_grow, clk, arst_n, done && result.status == fbpc_pkg::ST_INSERT, fill_q == $past(fill_q) + FILL_W'(1), "insert without fill growth")
	`FBPC_ASSERT_IMPLY(a_done_source, clk, arst_n, done, $past(state_q) == fbpc_pkg::S_UPDATE || $past(state_q) == fbpc_pkg::S_SCAN || $past(start && !busy), "result without transfer")

endmodule

>>> tb/tb_flow_byte_packet_counter.sv
// ----------------------------------------------------------------------------
// Flow byte/packet counter testbench
// Drives count and query transfers into the flow table and checks every
// result against a local model of the LRU table. A directed opening covers
// the field extremes, the drop paths and the query paths. It is followed by
// a fill that overflows the table and by a mixed stream of hits, new flows,
// evictions, queries and dropped frames, sent in bursts with random gaps.
// ----------------------------------------------------------------------------
module tb_flow_byte_packet_counter;
	timeunit 1ns;
	timeprecision 1ps;

	import fbpc_pkg::*;

	localparam int TABLE_ENTRIES  = 256;
	localparam int FILL_FLOWS     = TABLE_ENTRIES + 14;
	localparam int MIXED_ITEMS    = 480;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int SETTLE_CYCLES  = TABLE_ENTRIES + 8;

	typedef struct {
		logic [31:0] addr;
		logic [15:0] iface;
		logic        dir;
	} flow_id_t;

	class flow_ledger #(int SLOTS = 256);
		bit                occupied[SLOTS];
		logic [KEY_W-1:0]  slot_key[SLOTS];
		logic [CNT_W-1:0]  byte_total[SLOTS];
		logic [CNT_W-1:0]  pkt_total[SLOTS];
		int unsigned       rank[SLOTS];
		out_t              awaited_counts[$];
		int unsigned       tally[8];
		int                errors;
		int                results_seen;

		function new();
			foreach (occupied[i]) begin
				occupied[i]   = 1'b0;
				slot_key[i]   = '0;
				byte_total[i] = '0;
				pkt_total[i]  = '0;
				rank[i]       = 0;
			end
			foreach (tally[i])
				tally[i] = 0;
			errors       = 0;
			results_seen = 0;
		endfunction

		function int lookup(logic [KEY_W-1:0] k);
			for (int i = 0; i < SLOTS; i++)
				if (occupied[i] && slot_key[i] == k)
					return i;
			return -1;
		endfunction

		// make idx the most recent; younger entries age by one
		function void promote(int idx, int unsigned old_rank);
			for (int i = 0; i < SLOTS; i++)
				if (i != idx && occupied[i] && rank[i] < old_rank)
					rank[i]++;
			rank[idx] = 0;
		endfunction

		function void log_transfer(in_t it);
			out_t             exp_res;
			logic [31:0]      remote;
			logic [KEY_W-1:0] k;
			int               idx;
			exp_res = '0;
			if (it.mode) begin
				idx = lookup({it.query_addr, it.iface_index, it.flow_dir});
				if (idx < 0) begin
					exp_res.status = ST_Q_MISS;
				end else begin
					exp_res.status       = ST_Q_FOUND;
					exp_res.byte_count   = byte_total[idx];
					exp_res.packet_count = pkt_total[idx];
				end
			end else if (!it.headers_complete) begin
				exp_res.status = ST_TRUNC;
			end else if (it.ether_type != ETHERTYPE_IPV4) begin
				exp_res.status = ST_NOT_IPV4;
			end else begin
				remote = it.flow_dir ? it.dest_addr : it.source_addr;
				if (remote[31:24] == LOOPBACK_OCTET) begin
					exp_res.status = ST_LOOPBACK;
				end else begin
					k   = {remote, it.iface_index, it.flow_dir};
					idx = lookup(k);
					if (idx >= 0) begin
						byte_total[idx] = byte_total[idx] + CNT_W'(it.frame_length);
						pkt_total[idx]  = pkt_total[idx] + CNT_W'(1);
						promote(idx, rank[idx]);
						exp_res.status = ST_HIT;
					end else begin
						for (int i = 0; i < SLOTS; i++)
							if (!occupied[i]) begin
								idx = i;
								break;
							end
						if (idx >= 0) begin
							occupied[idx] = 1'b1;
							promote(idx, SLOTS);
							exp_res.status = ST_INSERT;
						end else begin
							idx = 0;
							for (int i = 1; i < SLOTS; i++)
								if (rank[i] > rank[idx])
									idx = i;
							promote(idx, rank[idx]);
							exp_res.status = ST_EVICT;
						end
						slot_key[idx]   = k;
						byte_total[idx] = CNT_W'(it.frame_length);
						pkt_total[idx]  = CNT_W'(1);
					end
					exp_res.byte_count   = byte_total[idx];
					exp_res.packet_count = pkt_total[idx];
				end
			end
			tally[int'(exp_res.status)]++;
			awaited_counts.push_back(exp_res);
		endfunction

		task report_mismatch(string msg);
			$display("[%0t] mismatch: %s", $time, msg);
			errors++;
		endtask

		task check_result(out_t got);
			out_t want;
			results_seen++;
			if (awaited_counts.size() == 0) begin
				report_mismatch($sformatf("result %0d (status %0d) has no pending transfer",
					results_seen, got.status));
				return;
			end
			want = awaited_counts.pop_front();
			if (got.status !== want.status)
				report_mismatch($sformatf("result %0d status %0d, want %0d",
					results_seen, got.status, want.status));
			if (got.byte_count !== want.byte_count)
				report_mismatch($sformatf("result %0d byte_count %0h, want %0h",
					results_seen, got.byte_count, want.byte_count));
			if (got.packet_count !== want.packet_count)
				report_mismatch($sformatf("result %0d packet_count %0h, want %0h",
					results_seen, got.packet_count, want.packet_count));
		endtask

		task check_drained();
			if (awaited_counts.size() != 0)
				report_mismatch($sformatf("%0d results never arrived", awaited_counts.size()));
		endtask
	endclass

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	in_t  item;
	logic done;
	out_t result;

	flow_ledger #(TABLE_ENTRIES) ledger;
	flow_id_t                    flows[$];
	int                          burst_left;
	int                          items_sent;

	flow_byte_packet_counter #(
		.TABLE_ENTRIES(TABLE_ENTRIES)
	) u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.item   (item),
		.done   (done),
		.result (result)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic in_t item_of(bit m, bit c, logic [15:0] et, logic [31:0] sa,
		logic [31:0] da, logic [15:0] ifc, bit d, logic [15:0] len, logic [31:0] qa);
		in_t it;
		it.mode             = m;
		it.headers_complete = c;
		it.ether_type       = et;
		it.source_addr      = sa;
		it.dest_addr        = da;
		it.iface_index      = ifc;
		it.flow_dir         = d;
		it.frame_length     = len;
		it.query_addr       = qa;
		return it;
	endfunction

	function automatic in_t random_item();
		return item_of(1'($urandom), 1'($urandom), 16'($urandom), $urandom, $urandom,
			16'($urandom), 1'($urandom), 16'($urandom), $urandom);
	endfunction

	function automatic flow_id_t fresh_flow();
		flow_id_t f;
		f.addr = $urandom;
		if (f.addr[31:24] == LOOPBACK_OCTET)
			f.addr[24] = ~f.addr[24];
		f.iface = 16'($urandom);
		f.dir   = 1'($urandom);
		return f;
	endfunction

	function automatic in_t packet_for(flow_id_t f);
		in_t it;
		it = random_item();
		it.mode             = 1'b0;
		it.headers_complete = 1'b1;
		it.ether_type       = ETHERTYPE_IPV4;
		it.iface_index      = f.iface;
		it.flow_dir         = f.dir;
		if (f.dir)
			it.dest_addr = f.addr;
		else
			it.source_addr = f.addr;
		if ($urandom_range(0, 9) == 0)
			it.frame_length = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
		return it;
	endfunction

	function automatic in_t query_for(flow_id_t f);
		in_t it;
		it = random_item();
		it.mode        = 1'b1;
		it.query_addr  = f.addr;
		it.iface_index = f.iface;
		it.flow_dir    = f.dir;
		return it;
	endfunction

	function automatic in_t dropped_frame();
		in_t         it;
		int unsigned pick;
		it      = random_item();
		it.mode = 1'b0;
		pick    = $urandom_range(0, 99);
		if (pick < 30) begin
			it.headers_complete = 1'b0;
			if ($urandom_range(0, 1))
				it.ether_type = ETHERTYPE_IPV4;
		end else if (pick < 60) begin
			it.headers_complete = 1'b1;
			if (it.ether_type == ETHERTYPE_IPV4)
				it.ether_type[0] = 1'b1;
		end else if (pick < 85) begin
			it.headers_complete = 1'b1;
			it.ether_type       = ETHERTYPE_IPV4;
			if (it.flow_dir)
				it.dest_addr[31:24] = LOOPBACK_OCTET;
			else
				it.source_addr[31:24] = LOOPBACK_OCTET;
		end else begin
			it.mode = 1'($urandom);
		end
		return it;
	endfunction

	task automatic send_item(in_t it);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
			if (gap != 0) begin
				start <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		start <= 1'b1;
		item  <= it;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		ledger.log_transfer(it);
		items_sent++;
	endtask

	task automatic wait_for_results();
		start      <= 1'b0;
		burst_left = 0;
		do
			@(posedge clk);
		while (ledger.awaited_counts.size() != 0);
	endtask

	always @(posedge clk)
		if (arst_n && done)
			ledger.check_result(result);

	initial begin
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((start && !busy) || done)
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("[%0t] watchdog: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
		$display("flow_byte_packet_counter regression: fail");
		$finish;
	end

	initial begin
		in_t         opening[$];
		flow_id_t    f;
		int unsigned pick;
		int          depth;
		ledger     = new();
		burst_left = 0;
		items_sent = 0;
		arst_n     = 1'b0;
		start      = 1'b0;
		item       = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty table, field extremes, drop order, query paths
		opening.push_back(item_of(1'b1, 1'b1, ETHERTYPE_IPV4, 32'h0, 32'h0,
			16'h0000, 1'b0, 16'h0000, 32'h0A000001));
		opening.push_back(item_of(1'b0, 1'b1, ETHERTYPE_IPV4, 32'h00000000, 32'hFFFFFFFF,
			16'h0000, 1'b0, 16'h0000, $urandom));
		opening.push_back(item_of(1'b0, 1'b1, ETHERTYPE_IPV4, 32'h00000000, 32'h12345678,
			16'h0000, 1'b0, 16'hFFFF, $urandom));
		opening.push_back(item_of(1'b0, 1'b1, ETHERTYPE_IPV4, 32'h7F000000, 32'hFFFFFFFF,
			16'hFFFF, 1'b1, 16'hFFFF, $urandom));
		opening.push_back(item_of(1'b0, 1'b1, ETHERTYPE_IPV4, 32'hFFFFFFFF, 32'h7F000001,
			16'hFFFF, 1'b0, 16'h0040, $urandom));
		opening.push_back(item_of(1'b0, 1'b1, ETHERTYPE_IPV4, 32'h01020304, 32'hFFFFFFFF,
			16'hFFFE, 1'b1, 16'h0100, $urandom));
		opening.push_back(item_of(1'b0, 1'b0, 16'h86DD, 32'h0A000001, 32'h0A000002,
			16'h0001, 1'b0, 16'h0200, $urandom));
		opening.push_back(item_of(1'b0, 1'b0, ETHERTYPE_IPV4, 32'h7F000001, 32'h0A000002,
			16'h0001, 1'b0, 16'h0200, $urandom));
		opening.push_back(item_of(1'b0, 1'b1, 16'h0000, 32'h0A000001, 32'h0A000002,
			16'h0001, 1'b0, 16'h0200, $urandom));
		opening.push_back(item_of(1'b0, 1'b1, 16'hFFFF, 32'h0A000001, 32'h0A000002,
			16'h0001, 1'b1, 16'h0200, $urandom));
		opening.push_back(item_of(1'b0, 1'b1, 16'h0801, 32'h0A000001, 32'h0A000002,
			16'h0001, 1'b0, 16'h0200, $urandom));
		opening.push_back(item_of(1'b0, 1'b1, 16'h0008, 32'h0A000001, 32'h0A000002,
			16'h0001, 1'b1, 16'h0200, $urandom));
		opening.push_back(item_of(1'b0, 1'b1, ETHERTYPE_IPV4, 32'h7F000001, 32'h0A000002,
			16'h0002, 1'b0, 16'h0200, $urandom));
		opening.push_back(item_of(1'b0, 1'b1, ETHERTYPE_IPV4, 32'h0A000001, 32'h7FFFFFFF,
			16'h0002, 1'b1, 16'h0200, $urandom));
		opening.push_back(item_of(1'b0, 1'b1, ETHERTYPE_IPV4, 32'h7EFFFFFF, 32'h7F000000,
			16'h0003, 1'b0, 16'h0055, $urandom));
		opening.push_back(item_of(1'b0, 1'b1, ETHERTYPE_IPV4, 32'h7F0000FF, 32'h80000000,
			16'h0003, 1'b1, 16'h00AA, $urandom));
		opening.push_back(item_of(1'b1, 1'b1, ETHERTYPE_IPV4, $urandom, $urandom,
			16'h0000, 1'b0, 16'($urandom), 32'h00000000));
		opening.push_back(item_of(1'b1, 1'b0, 16'hFFFF, $urandom, $urandom,
			16'hFFFF, 1'b1, 16'($urandom), 32'hFFFFFFFF));
		opening.push_back(item_of(1'b1, 1'b1, ETHERTYPE_IPV4, $urandom, $urandom,
			16'h0000, 1'b1, 16'($urandom), 32'h00000000));
		opening.push_back(item_of(1'b1, 1'b1, ETHERTYPE_IPV4, $urandom, $urandom,
			16'h0002, 1'b0, 16'($urandom), 32'h7F000001));
		opening.push_back(item_of(1'b0, 1'b1, ETHERTYPE_IPV4, 32'h00000000, 32'hFFFFFFFF,
			16'hFFFF, 1'b1, 16'h0001, $urandom));
		foreach (opening[i])
			send_item(opening[i]);
		wait_for_results();

		// overflow the table with fresh flows
		repeat (FILL_FLOWS) begin
			f = fresh_flow();
			flows.push_back(f);
			send_item(packet_for(f));
		end
		wait_for_results();

		// mixed traffic: recent flows hit, old ones may have been evicted
		repeat (MIXED_ITEMS) begin
			pick  = $urandom_range(0, 99);
			depth = (flows.size() < 20) ? flows.size() : 20;
			if (pick < 30) begin
				f = fresh_flow();
				flows.push_back(f);
				send_item(packet_for(f));
			end else if (pick < 58) begin
				send_item(packet_for(flows[flows.size() - 1 - $urandom_range(0, depth - 1)]));
			end else if (pick < 70) begin
				send_item(packet_for(flows[$urandom_range(0, flows.size() - 1)]));
			end else if (pick < 78) begin
				send_item(query_for(flows[flows.size() - 1 - $urandom_range(0, depth - 1)]));
			end else if (pick < 84) begin
				if ($urandom_range(0, 1))
					send_item(query_for(flows[$urandom_range(0, flows.size() - 1)]));
				else
					send_item(query_for(fresh_flow()));
			end else begin
				send_item(dropped_frame());
			end
		end
		wait_for_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		ledger.check_drained();

		$display("covered %0d transfers, %0d results: %0d hits, %0d inserts, %0d evictions",
			items_sent, ledger.results_seen, ledger.tally[int'(ST_HIT)],
			ledger.tally[int'(ST_INSERT)], ledger.tally[int'(ST_EVICT)]);
		$display("dropped %0d truncated, %0d non-IPv4, %0d loopback; queries %0d found, %0d missing",
			ledger.tally[int'(ST_TRUNC)], ledger.tally[int'(ST_NOT_IPV4)],
			ledger.tally[int'(ST_LOOPBACK)], ledger.tally[int'(ST_Q_FOUND)],
			ledger.tally[int'(ST_Q_MISS)]);
		if (ledger.errors == 0)
			$display("flow_byte_packet_counter regression: pass");
		else
			$display("flow_byte_packet_counter regression: fail");
		$finish;
	end

endmodule

>>> flow_byte_packet_counter.f
+incdir+rtl
rtl/fbpc_pkg.sv
rtl/fbpc_ram.sv
rtl/fbpc_match.sv
rtl/flow_byte_packet_counter.sv
tb/tb_flow_byte_packet_counter.sv
